// ===== rtl/core/sacf_pkg.sv =====
// Package with shared constants and types of the set associative cache lookup unit.
`timescale 1ns / 1ps
package sacf_pkg;
	localparam int MaxSets = 256;
	localparam int MaxWays = 8;
	localparam int AddrBits = 32;
	localparam int SetW = $clog2(MaxSets);
	localparam int WayW = $clog2(MaxWays);
	localparam int WayCntW = WayW + 1;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 5;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_SET_BITS    = 2'd1,
		CFG_WAYS_IN_USE = 2'd2,
		CFG_NONE        = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DONE
	} back_state_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic                 mode;
		logic [SetW-1:0]      set;
		logic [AddrBits-1:0]  tag;
		logic [WayCntW-1:0]   ways;
	} lookup_req_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way;
		logic [31:0] read_total;
		logic [31:0] write_total;
		logic [31:0] read_hits;
		logic [31:0] write_hits;
		logic [31:0] read_misses;
		logic [31:0] write_misses;
	} lookup_rsp_t;
endpackage

// ===== rtl/core/sacf_stream_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface sacf_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] address;
	modport source (output valid, mode, address, input ready);
	modport sink (input valid, mode, address, output ready);
endinterface

interface sacf_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [2:0]  way;
	logic [31:0] read_total;
	logic [31:0] write_total;
	logic [31:0] read_hits;
	logic [31:0] write_hits;
	logic [31:0] read_misses;
	logic [31:0] write_misses;
	modport source (output valid, hit, way, read_total, write_total, read_hits,
		write_hits, read_misses, write_misses, input ready);
	modport sink (input valid, hit, way, read_total, write_total, read_hits,
		write_hits, read_misses, write_misses, output ready);
endinterface

// ===== rtl/core/sacf_front.sv =====
// Front end: configuration registers, address split and a two entry request queue.
`timescale 1ns / 1ps
module sacf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sacf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sacf_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_mode,
	input  logic [31:0]                   in_address,
	output logic                          q_valid,
	input  logic                          q_pop,
	output sacf_pkg::lookup_req_t         q_req
);
	import sacf_pkg::*;

	logic [4:0] offset_bits_q;
	logic [3:0] set_bits_q;
	logic [3:0] ways_q;
	lookup_req_t cls;
	lookup_req_t slot_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	logic [AddrBits-1:0] block;
	logic [3:0] sb;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 5'd6;
			set_bits_q <= 4'd6;
			ways_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_SET_BITS:    set_bits_q <= cfg_data[3:0];
				CFG_WAYS_IN_USE: ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// Offsets of the full address width or more give block number zero.
		block = ({1'b0, offset_bits_q} >= 6'(AddrBits)) ? '0 : (in_address >> offset_bits_q);
		sb = (set_bits_q > 4'(SetW)) ? 4'(SetW) : set_bits_q;
		cls.mode = in_mode;
		cls.set = SetW'(block & ((AddrBits'(1) << sb) - AddrBits'(1)));
		cls.tag = block >> sb;
		if (ways_q == 4'd0) cls.ways = WayCntW'(1);
		else if (ways_q > 4'(MaxWays)) cls.ways = WayCntW'(MaxWays);
		else cls.ways = WayCntW'(ways_q);
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_req = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/core/sacf_back.sv =====
// Back end: set memories, tag compare, FIFO replacement and the access counters.
`timescale 1ns / 1ps
module sacf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  sacf_pkg::lookup_req_t q_req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output sacf_pkg::lookup_rsp_t rsp
);
	import sacf_pkg::*;

	back_state_t state_q, state_d;
	logic [SetW-1:0] clr_q;
	logic [MaxWays-1:0] valid_mem [MaxSets];
	logic [MaxWays*AddrBits-1:0] tag_mem [MaxSets];
	logic [WayW-1:0] ptr_mem [MaxSets];
	logic [MaxWays-1:0] valid_rd_q;
	logic [MaxWays*AddrBits-1:0] tag_rd_q;
	logic [WayW-1:0] ptr_rd_q;
	lookup_req_t req_q;
	logic hit;
	logic [WayW-1:0] hit_way, victim, next_ptr;
	logic [31:0] cnt_q [6];
	logic do_update, do_clear, take;
	logic hit_q;
	logic [2:0] way_q;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int w = MaxWays - 1; w >= 0; w--) begin
			if (WayCntW'(w) < req_q.ways && valid_rd_q[w] &&
					tag_rd_q[w*AddrBits +: AddrBits] == req_q.tag) begin
				hit = 1'b1;
				hit_way = WayW'(w);
			end
		end
		victim = (WayCntW'(ptr_rd_q) < req_q.ways) ? ptr_rd_q : '0;
		next_ptr = (WayCntW'(victim) + WayCntW'(1) >= req_q.ways) ? '0 : victim + WayW'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == SetW'(MaxSets - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (q_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_DONE;
			ST_DONE:  if (rsp_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take = (state_q == ST_IDLE) && q_valid;
		q_pop = take;
		do_update = (state_q == ST_READ);
		do_clear = (state_q == ST_CLEAR);
		rsp_valid = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			for (int i = 0; i < 6; i++) cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (do_clear) clr_q <= clr_q + SetW'(1);
			if (do_update) begin
				cnt_q[{2'b0, req_q.mode}] <= cnt_q[{2'b0, req_q.mode}] + 32'd1;
				if (hit) cnt_q[3'(2) + 3'(req_q.mode)] <= cnt_q[3'(2) + 3'(req_q.mode)] + 32'd1;
				else cnt_q[3'(4) + 3'(req_q.mode)] <= cnt_q[3'(4) + 3'(req_q.mode)] + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= q_req;
			valid_rd_q <= valid_mem[q_req.set];
			tag_rd_q <= tag_mem[q_req.set];
			ptr_rd_q <= ptr_mem[q_req.set];
		end
		if (do_clear) begin
			valid_mem[clr_q] <= '0;
			ptr_mem[clr_q] <= '0;
		end else if (do_update) begin
			if (!hit) begin
				valid_mem[req_q.set] <= valid_rd_q | (MaxWays'(1) << victim);
				tag_mem[req_q.set] <= (tag_rd_q & ~({{(MaxWays-1)*AddrBits{1'b0}},
					{AddrBits{1'b1}}} << (victim*AddrBits))) |
					({{(MaxWays-1)*AddrBits{1'b0}}, req_q.tag} << (victim*AddrBits));
				ptr_mem[req_q.set] <= next_ptr;
			end
			hit_q <= hit;
			way_q <= 3'(hit ? hit_way : victim);
		end
	end

	assign rsp.hit = hit_q;
	assign rsp.way = way_q;
	assign rsp.read_total = cnt_q[0];
	assign rsp.write_total = cnt_q[1];
	assign rsp.read_hits = cnt_q[2];
	assign rsp.write_hits = cnt_q[3];
	assign rsp.read_misses = cnt_q[4];
	assign rsp.write_misses = cnt_q[5];
endmodule

// ===== rtl/core/set_assoc_cache_fifo_lookup_unit.sv =====
// Top level of the set associative cache lookup unit with FIFO replacement.
// Requests arrive on req (mode 0 read, 1 write, byte address) and results
// leave on rsp as hit, way and six running access counters.
// The front splits each address by the configured block offset and set
// count and queues up to two classified requests. The back reads the set's
// valid bits, tags and fill pointer, compares all ways at once, allocates on
// a miss, and holds the result until it is taken.
// In an empty unit the request passes the queue, the set read and the update
// before the result becomes valid; one request is looked up at a time, so the
// next request is taken only after the result is handed over, through the
// read, update and hand over steps of the single set memory port.
// After reset the back clears valid bits and pointers of all 256 sets, one
// set a cycle, before it takes the first request; the front still accepts up
// to two requests meanwhile. Configuration writes are taken at any time. A
// stalled receiver holds the result and the queue fills up.
`timescale 1ns / 1ps
module set_assoc_cache_fifo_lookup_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sacf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sacf_pkg::CfgDataW-1:0] cfg_data,
	sacf_req_if.sink                      req,
	sacf_rsp_if.source                    rsp
);
	import sacf_pkg::*;

	logic q_valid, q_pop, rsp_valid;
	lookup_req_t q_req;
	lookup_rsp_t rsp_data;

	sacf_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(req.valid), .in_ready(req.ready),
		.in_mode(req.mode), .in_address(req.address),
		.q_valid, .q_pop, .q_req
	);

	sacf_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.rsp_valid, .rsp_ready(rsp.ready), .rsp(rsp_data)
	);

	assign rsp.valid = rsp_valid;
	assign rsp.hit = rsp_data.hit;
	assign rsp.way = rsp_data.way;
	assign rsp.read_total = rsp_data.read_total;
	assign rsp.write_total = rsp_data.write_total;
	assign rsp.read_hits = rsp_data.read_hits;
	assign rsp.write_hits = rsp_data.write_hits;
	assign rsp.read_misses = rsp_data.read_misses;
	assign rsp.write_misses = rsp_data.write_misses;
endmodule

// ===== rtl/core/sacf_checker.sv =====
// Port level checker for the cache lookup unit, bound to the top level.
`timescale 1ns / 1ps
module sacf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] read_total,
	input logic [31:0] write_total,
	input logic [31:0] read_hits,
	input logic [31:0] write_hits,
	input logic [31:0] read_misses,
	input logic [31:0] write_misses
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_total))
		else $error("result dropped while stalled");
	a_rd_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> read_total == read_hits + read_misses)
		else $error("read counters disagree");
	a_wr_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> write_total == write_hits + write_misses)
		else $error("write counters disagree");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready ##1 rsp_valid |->
		(read_total + write_total) == $past(read_total + write_total, 1) + 32'd1 ||
		$past(rsp_valid, 1) == 1'b0)
		else $error("access count skipped");
endmodule

bind set_assoc_cache_fifo_lookup_unit sacf_checker u_checker (
	.clk, .arst_n, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.read_total(rsp.read_total), .write_total(rsp.write_total),
	.read_hits(rsp.read_hits), .write_hits(rsp.write_hits),
	.read_misses(rsp.read_misses), .write_misses(rsp.write_misses)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the set associative cache lookup unit with FIFO replacement.
`timescale 1ns / 1ps
module tb;
	import sacf_pkg::*;

	// One access as the sender offers it.
	typedef struct {
		logic        mode;
		logic [31:0] address;
	} access_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	sacf_req_if req ();
	sacf_rsp_if rsp ();

	set_assoc_cache_fifo_lookup_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req),
		.rsp(rsp)
	);

	// Requests waiting to be offered, and lookup results the unit still owes.
	access_t     access_q[$];
	lookup_rsp_t lookup_q[$];
	logic [31:0] recent_addr[$];

	// Shadow copy of the cache state and the geometry registers.
	logic        shadow_valid[MaxSets][MaxWays];
	logic [31:0] shadow_tag[MaxSets][MaxWays];
	int          shadow_fill[MaxSets];
	logic [31:0] cnt_rd, cnt_wr, cnt_rd_hit, cnt_wr_hit, cnt_rd_miss, cnt_wr_miss;
	int          geo_offset, geo_sets, geo_ways;

	int send_idle_pct, rsp_stall_pct;
	logic send_hold, rsp_hold;
	int failures;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Works out hit, way and counters for one access and updates the shadow cache.
	function automatic lookup_rsp_t cache_lookup(logic m, logic [31:0] a);
		logic [31:0] blk;
		logic [31:0] tg;
		int sb, nw, s, victim;
		lookup_rsp_t r;
		blk = (geo_offset >= AddrBits) ? 32'd0 : a >> geo_offset;
		sb = (geo_sets > SetW) ? SetW : geo_sets;
		nw = (geo_ways == 0) ? 1 : (geo_ways > MaxWays) ? MaxWays : geo_ways;
		s = blk & ((32'd1 << sb) - 1);
		tg = blk >> sb;
		r = '0;
		if (m) cnt_wr++;
		else cnt_rd++;
		for (int w = nw - 1; w >= 0; w--) begin
			if (shadow_valid[s][w] && shadow_tag[s][w] == tg) begin
				r.hit = 1'b1;
				r.way = 3'(w);
			end
		end
		if (r.hit) begin
			if (m) cnt_wr_hit++;
			else cnt_rd_hit++;
		end else begin
			// A pointer left beyond a lowered way count restarts at way 0.
			victim = (shadow_fill[s] < nw) ? shadow_fill[s] : 0;
			if (m) cnt_wr_miss++;
			else cnt_rd_miss++;
			shadow_valid[s][victim] = 1'b1;
			shadow_tag[s][victim] = tg;
			shadow_fill[s] = (victim + 1 >= nw) ? 0 : victim + 1;
			r.way = 3'(victim);
		end
		r.read_total = cnt_rd;
		r.write_total = cnt_wr;
		r.read_hits = cnt_rd_hit;
		r.write_hits = cnt_wr_hit;
		r.read_misses = cnt_rd_miss;
		r.write_misses = cnt_wr_miss;
		return r;
	endfunction

	// Driver: offers queued requests and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= 1'b0;
			req.address <= '0;
		end else begin
			if (req.valid && req.ready)
				lookup_q.push_back(cache_lookup(req.mode, req.address));
			if (!req.valid || req.ready) begin
				if (access_q.size() > 0 && !send_hold &&
					$urandom_range(99) >= send_idle_pct) begin
					req.valid <= 1'b1;
					req.mode <= access_q[0].mode;
					req.address <= access_q[0].address;
					void'(access_q.pop_front());
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes results and compares them field by field with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		lookup_rsp_t exp_r;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (lookup_q.size() == 0) begin
					$error("result arrived with no request outstanding");
					failures++;
				end else begin
					exp_r = lookup_q.pop_front();
					if (rsp.hit !== exp_r.hit) begin
						$error("hit: expected %0d, got %0d", exp_r.hit, rsp.hit);
						failures++;
					end
					if (rsp.way !== exp_r.way) begin
						$error("way: expected %0d, got %0d", exp_r.way, rsp.way);
						failures++;
					end
					if (rsp.read_total !== exp_r.read_total) begin
						$error("read_total: expected %0d, got %0d", exp_r.read_total,
							rsp.read_total);
						failures++;
					end
					if (rsp.write_total !== exp_r.write_total) begin
						$error("write_total: expected %0d, got %0d", exp_r.write_total,
							rsp.write_total);
						failures++;
					end
					if (rsp.read_hits !== exp_r.read_hits) begin
						$error("read_hits: expected %0d, got %0d", exp_r.read_hits,
							rsp.read_hits);
						failures++;
					end
					if (rsp.write_hits !== exp_r.write_hits) begin
						$error("write_hits: expected %0d, got %0d", exp_r.write_hits,
							rsp.write_hits);
						failures++;
					end
					if (rsp.read_misses !== exp_r.read_misses) begin
						$error("read_misses: expected %0d, got %0d", exp_r.read_misses,
							rsp.read_misses);
						failures++;
					end
					if (rsp.write_misses !== exp_r.write_misses) begin
						$error("write_misses: expected %0d, got %0d", exp_r.write_misses,
							rsp.write_misses);
						failures++;
					end
				end
			end
			rsp.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Blocks until every queued request has been accepted and answered, then lets
	// the unit settle.
	task automatic drain();
		wait (access_q.size() == 0 && !req.valid && lookup_q.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OFFSET_BITS: geo_offset = value & 5'h1f;
			CFG_SET_BITS: geo_sets = value & 4'hf;
			CFG_WAYS_IN_USE: geo_ways = value & 4'hf;
			default: ;
		endcase
	endtask

	// Sets the whole geometry; the unused index is poked too and must be ignored.
	task automatic set_geometry(int off, int sb, int nw);
		write_reg(CFG_OFFSET_BITS, off);
		write_reg(CFG_SET_BITS, sb);
		write_reg(CFG_WAYS_IN_USE, nw);
		write_reg(CFG_NONE, $urandom_range(31));
	endtask

	task automatic push_access(logic m, logic [31:0] a);
		access_t it;
		it.mode = m;
		it.address = a;
		access_q.push_back(it);
	endtask

	// Random accesses: mostly revisits of recent blocks with fresh low bits so
	// that hits, conflicts and evictions happen, the rest fully random.
	task automatic push_random(int n);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			if (recent_addr.size() > 0 && $urandom_range(3) != 0) begin
				a = recent_addr[$urandom_range(recent_addr.size() - 1)];
				a ^= $urandom_range(255) << $urandom_range(4);
			end else begin
				a = $urandom();
			end
			recent_addr.push_back(a);
			if (recent_addr.size() > 24) void'(recent_addr.pop_front());
			push_access(1'($urandom_range(1)), a);
		end
	endtask

	initial begin
		// Geometries visited by the random part, extremes among them.
		int offs[8] = '{6, 0, 16, 31, 4, 12, 2, 9};
		int sbs[8]  = '{6, 0, 8, 15, 2, 1, 3, 8};
		int nws[8]  = '{2, 1, 8, 15, 0, 4, 3, 8};
		failures = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_hold = 1'b0;
		rsp_hold = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NONE;
		cfg_data = '0;
		geo_offset = 6;
		geo_sets = 6;
		geo_ways = 2;
		cnt_rd = 0; cnt_wr = 0; cnt_rd_hit = 0;
		cnt_wr_hit = 0; cnt_rd_miss = 0; cnt_wr_miss = 0;
		foreach (shadow_valid[s, w]) begin
			shadow_valid[s][w] = 1'b0;
			shadow_tag[s][w] = '0;
		end
		foreach (shadow_fill[s]) shadow_fill[s] = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under reset geometry: address extremes, both modes,
		// and eviction by a third tag in a two-way set.
		push_access(1'b0, 32'h0000_0000);
		push_access(1'b1, 32'h0000_0000);
		push_access(1'b0, 32'hffff_ffff);
		push_access(1'b1, 32'hffff_ffff);
		push_access(1'b0, 32'h0000_1000);
		push_access(1'b1, 32'h0000_2000);
		push_access(1'b0, 32'h0000_0000);
		push_access(1'b1, 32'h0000_1000);
		drain();

		// Fill five ways of set 0, then lower the way count so the pointer is stale.
		set_geometry(6, 6, 8);
		for (int t = 1; t <= 5; t++) push_access(t[0], t << 20);
		drain();
		set_geometry(6, 6, 2);
		push_access(1'b0, 32'h0600_0000);
		push_access(1'b1, 32'h0700_0000);
		push_access(1'b0, 32'h0100_0000);
		drain();

		// Large offset, oversized set count and out of range way counts.
		set_geometry(31, 15, 0);
		push_access(1'b0, 32'h1234_5678);
		push_access(1'b1, 32'h8765_4321);
		drain();
		set_geometry(16, 15, 15);
		push_access(1'b0, 32'hfedc_ba98);
		push_access(1'b1, 32'h0001_0000);
		push_access(1'b0, 32'hfedc_0000);
		drain();

		// Random part: eight geometries, each under one of four idling patterns.
		for (int seg = 0; seg < 8; seg++) begin
			set_geometry(offs[seg], sbs[seg], nws[seg]);
			case (seg % 4)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 51; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 51; end
				default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
			endcase
			if (seg == 0) begin
				// The receiver holds off while requests keep coming, so the
				// queue fills and the unit stalls its input.
				fork
					begin
						@(posedge clk);
						rsp_hold <= 1'b1;
						repeat (300) @(posedge clk);
						rsp_hold <= 1'b0;
					end
				join_none
			end
			push_random(70);
			if (seg == 3) begin
				// The sender pauses until every outstanding request is answered.
				@(posedge clk);
				send_hold <= 1'b1;
				wait (lookup_q.size() == 0 && !req.valid);
				@(posedge clk);
				send_hold <= 1'b0;
			end
			push_random(65);
			drain();
		end

		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
